### rtl/core/lkv_pkg.sv
package lkv_pkg;

  localparam int unsigned MAX_ENTRIES_DEF = 16;
  localparam int unsigned KEY_W   = 32;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned CAP_W   = 5;
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  localparam logic [CAP_W-1:0]   CAP_RESET  = CAP_W'(16);
  localparam logic [VALUE_W-1:0] MISS_VALUE = '1;

  // Register index, taken from paddr[2].
  localparam logic REG_CAPACITY = 1'b0;

  typedef enum logic {
    OP_GET = 1'b0,
    OP_SET = 1'b1
  } lkv_op_e;

  typedef struct packed {
    logic               valid;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } lkv_entry_t;

  typedef struct packed {
    logic set_en;
    logic cap_wr;
  } lkv_ctrl_t;

endpackage

### rtl/core/lkv_cell.sv
module lkv_cell #(
  parameter int unsigned Index = 0,
  parameter int unsigned CntW  = 5
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  lkv_pkg::lkv_ctrl_t        ctrl_i,
  input  logic [CntW-1:0]           usable_i,
  input  logic [lkv_pkg::KEY_W-1:0] key_i,
  input  lkv_pkg::lkv_entry_t       prev_i,
  input  logic                      match_before_i,
  output logic                      match_before_o,
  output logic                      match_o,
  output lkv_pkg::lkv_entry_t       entry_o
);
  import lkv_pkg::*;

  logic               valid_q, valid_d;
  logic [KEY_W-1:0]   key_q, key_d;
  logic [VALUE_W-1:0] value_q, value_d;
  logic               in_range;
  logic               take;

  assign in_range       = CntW'(Index) < usable_i;
  assign match_o        = valid_q & (key_q == key_i);
  assign match_before_o = match_before_i | match_o;

  // A set shifts every cell up to and including the first matching one,
  // or up to the last usable position when the key is not present.
  assign take = ctrl_i.set_en & in_range & ~match_before_i;

  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    value_d = value_q;
    if (take) begin
      valid_d = prev_i.valid;
      key_d   = prev_i.key;
      value_d = prev_i.value;
    end else if (ctrl_i.cap_wr && !in_range) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    value_q <= value_d;
  end

  assign entry_o = '{valid: valid_q, key: key_q, value: value_q};

endmodule

### rtl/core/lru_key_value_table.sv
// Get: the result word appears in the cycle after the request is accepted.
// Set: takes effect at the accepting edge and returns no word.
// Throughput is one request per cycle while out_ready_i keeps the result word moving;
// the chain of entry cells compares all keys in parallel and shifts by one position at the accepting edge.
// Reset clears every entry's valid bit and sets the capacity register to 16;
// no clearing pass is needed.
module lru_key_value_table #(
  parameter int unsigned MaxEntries = lkv_pkg::MAX_ENTRIES_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic                                  op_i,
  input  logic signed [lkv_pkg::KEY_W-1:0]      key_i,
  input  logic signed [lkv_pkg::VALUE_W-1:0]    data_in_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic                                  hit_o,
  output logic signed [lkv_pkg::VALUE_W-1:0]    data_out_o,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [lkv_pkg::APB_ADDR_W-1:0]        paddr,
  input  logic [lkv_pkg::APB_DATA_W-1:0]        pwdata,
  output logic [lkv_pkg::APB_DATA_W-1:0]        prdata,
  output logic                                  pready
);
  import lkv_pkg::*;

  localparam int unsigned IdxBits = $clog2(MaxEntries + 1);
  localparam int unsigned CntW    = (IdxBits > CAP_W) ? IdxBits : CAP_W;

  logic [CAP_W-1:0] cap_q, cap_d;
  logic [CntW-1:0]  cap_ext;
  logic [CntW-1:0]  usable;
  logic             cap_wr;

  logic in_fire, get_fire, set_fire;
  logic out_valid_q, out_valid_d;
  logic hit_q;
  logic [VALUE_W-1:0] data_q;

  lkv_ctrl_t          ctrl;
  lkv_entry_t         new_entry;
  lkv_entry_t         entry [MaxEntries];
  logic [MaxEntries:0]   match_chain;
  logic [MaxEntries-1:0] match_vec;
  logic [MaxEntries-1:0] valid_vec;
  logic [VALUE_W-1:0]    sel_value;

  // Configuration port.
  assign pready = 1'b1;
  assign cap_wr = psel & penable & pwrite & (paddr[2] == REG_CAPACITY);
  assign cap_d  = cap_wr ? pwdata[CAP_W-1:0] : cap_q;
  assign prdata = (paddr[2] == REG_CAPACITY) ? APB_DATA_W'(cap_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else begin
      cap_q <= cap_d;
    end
  end

  // Usable size follows the value being written, so a write drops the
  // entries beyond the new size at the same edge.
  assign cap_ext = CntW'(cap_d);
  always_comb begin
    if (cap_ext == '0) begin
      usable = CntW'(1);
    end else if (cap_ext > CntW'(MaxEntries)) begin
      usable = CntW'(MaxEntries);
    end else begin
      usable = cap_ext;
    end
  end

  // Request handshake.
  assign in_ready_o = ~out_valid_q | out_ready_i;
  assign in_fire    = in_valid_i & in_ready_o;
  assign get_fire   = in_fire & (op_i == OP_GET);
  assign set_fire   = in_fire & (op_i == OP_SET);

  assign ctrl      = '{set_en: set_fire, cap_wr: cap_wr};
  assign new_entry = '{valid: 1'b1, key: $unsigned(key_i), value: $unsigned(data_in_i)};
  assign match_chain[0] = 1'b0;

  for (genvar g = 0; g < MaxEntries; g++) begin : g_cell
    lkv_entry_t prev;
    if (g == 0) begin : g_front
      assign prev = new_entry;
    end else begin : g_rest
      assign prev = entry[g-1];
    end

    lkv_cell #(
      .Index (g),
      .CntW  (CntW)
    ) u_cell (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .ctrl_i         (ctrl),
      .usable_i       (usable),
      .key_i          ($unsigned(key_i)),
      .prev_i         (prev),
      .match_before_i (match_chain[g]),
      .match_before_o (match_chain[g+1]),
      .match_o        (match_vec[g]),
      .entry_o        (entry[g])
    );

    assign valid_vec[g] = entry[g].valid;
  end

  // Keys are unique among valid entries, so at most one cell matches.
  always_comb begin
    sel_value = '0;
    for (int i = 0; i < MaxEntries; i++) begin
      if (match_vec[i]) begin
        sel_value = sel_value | entry[i].value;
      end
    end
  end

  // Result register.
  always_comb begin
    out_valid_d = out_valid_q;
    if (get_fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (get_fire) begin
      hit_q  <= match_chain[MaxEntries];
      data_q <= match_chain[MaxEntries] ? sel_value : MISS_VALUE;
    end
  end

  assign out_valid_o = out_valid_q;
  assign hit_o       = hit_q;
  assign data_out_o  = $signed(data_q);

  // No key may be held by two valid entries.
  a_unique_keys : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(match_vec))
    else $error("more than one entry matches the key");

  // Valid entries fill the front of the chain without gaps.
  a_valid_prefix : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_vec & (valid_vec + MaxEntries'(1))) == '0)
    else $error("gap in the valid entries");

  // An accepted get always leaves a result word behind.
  a_get_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    get_fire |=> out_valid_o)
    else $error("get accepted without a result word");

endmodule

### sim/tb_lru_key_value_table.sv
module tb_lru_key_value_table;
  timeunit 1ns;
  timeprecision 1ps;

  import lkv_pkg::*;

  localparam int unsigned DEPTH = MAX_ENTRIES_DEF;
  localparam int unsigned ITEMS_PER_PHASE = 150;
  localparam int unsigned IDLE_PCT = 25;
  localparam int unsigned CALM_PHASE = 6;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned DRAIN_SPACING = 250;
  localparam int unsigned REPORT_LIMIT = 10;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam logic [APB_ADDR_W-1:0] CAP_ADDR = {REG_CAPACITY, 2'b00};

  typedef struct {
    lkv_op_e            op;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] data;
  } kv_request_t;

  typedef struct {
    logic               hit;
    logic [VALUE_W-1:0] data;
  } lookup_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic                  op_i = 1'b0;
  logic [KEY_W-1:0]      key_i = '0;
  logic [VALUE_W-1:0]    data_in_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic                  hit_o;
  logic [VALUE_W-1:0]    data_out_o;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  lru_key_value_table #(.MaxEntries(DEPTH)) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .op_i       (op_i),
    .key_i      (key_i),
    .data_in_i  (data_in_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .hit_o      (hit_o),
    .data_out_o (data_out_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // Shadow copy of the table, kept in recency order with the newest entry at 0.
  logic [KEY_W-1:0]   tbl_key [DEPTH];
  logic [VALUE_W-1:0] tbl_val [DEPTH];
  bit                 tbl_vld [DEPTH];
  logic [CAP_W-1:0]   cap_reg = CAP_RESET;

  kv_request_t    requests_pending[$];
  lookup_result_t lookups_due[$];
  kv_request_t    cur_req;
  lookup_result_t want;
  logic [KEY_W-1:0] key_pool [DEPTH + 4];

  int unsigned queued_count = 0;
  int unsigned accepted_count = 0;
  int unsigned issued_count = 0;
  int unsigned drain_point = 200;
  int unsigned quiet_cycles = 0;
  int unsigned error_count = 0;
  bit          steady = 1'b0;

  int unsigned cap_plan [12] = '{16, 1, 31, 17, 5, 3, 16, 8, 2, 12, 24, 0};

  function automatic int unsigned usable_entries();
    int unsigned c = cap_reg;
    if (c == 0) c = 1;
    if (c > DEPTH) c = DEPTH;
    return c;
  endfunction

  function automatic void apply_capacity(logic [CAP_W-1:0] v);
    cap_reg = v;
    for (int i = usable_entries(); i < DEPTH; i++) tbl_vld[i] = 1'b0;
  endfunction

  function automatic void lru_apply(kv_request_t r);
    int unsigned c;
    int unsigned pos;
    int unsigned last;
    bit found;
    lookup_result_t res;
    c = usable_entries();
    found = 1'b0;
    pos = 0;
    for (int i = 0; i < c; i++) begin
      if (!found && tbl_vld[i] && tbl_key[i] == r.key) begin
        found = 1'b1;
        pos = i;
      end
    end
    if (r.op == OP_GET) begin
      res.hit = found;
      res.data = found ? tbl_val[pos] : MISS_VALUE;
      lookups_due.push_back(res);
      return;
    end
    // An update removes the old copy; a new key pushes the oldest one out.
    last = found ? pos : c - 1;
    for (int i = last; i > 0; i--) begin
      tbl_key[i] = tbl_key[i-1];
      tbl_val[i] = tbl_val[i-1];
      tbl_vld[i] = tbl_vld[i-1];
    end
    tbl_key[0] = r.key;
    tbl_val[0] = r.data;
    tbl_vld[0] = 1'b1;
  endfunction

  function automatic bit take_break();
    return !steady && ($urandom_range(0, 99) < IDLE_PCT);
  endfunction

  function automatic void queue_request(lkv_op_e op, logic [KEY_W-1:0] key,
                                        logic [VALUE_W-1:0] data);
    kv_request_t r;
    r.op = op;
    r.key = key;
    r.data = data;
    requests_pending.push_back(r);
    queued_count++;
  endfunction

  task automatic wait_idle();
    while (accepted_count != queued_count || lookups_due.size() != 0) @(posedge clk_i);
    // A set accepted last leaves no word behind, so let the block settle before going on.
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] v);
    logic [APB_DATA_W-1:0] word;
    word = $urandom();
    word[CAP_W-1:0] = v;
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CAP_ADDR;
    pwdata <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    apply_capacity(v);
  endtask

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Request driver.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        lru_apply(cur_req);
        accepted_count++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (issued_count == drain_point && lookups_due.size() != 0) begin
          // Hold off until every outstanding lookup word has come back.
          in_valid_i <= 1'b0;
        end else if (requests_pending.size() != 0 && !take_break()) begin
          if (issued_count == drain_point) begin
            drain_point += DRAIN_SPACING + $urandom_range(0, 99);
          end
          cur_req = requests_pending.pop_front();
          in_valid_i <= 1'b1;
          op_i <= cur_req.op;
          key_i <= cur_req.key;
          data_in_i <= cur_req.data;
          issued_count++;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (lookups_due.size() == 0) begin
          error_count++;
          if (error_count <= REPORT_LIMIT) begin
            $display("unexpected word: hit=%0b data_out=%h", hit_o, data_out_o);
          end
        end else begin
          want = lookups_due.pop_front();
          if (hit_o !== want.hit || data_out_o !== want.data) begin
            error_count++;
            if (error_count <= REPORT_LIMIT) begin
              $display("lookup mismatch: expected hit=%0b data_out=%h, got hit=%0b data_out=%h",
                       want.hit, want.data, hit_o, data_out_o);
            end
          end
        end
      end
      out_ready_i <= !take_break();
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int unsigned pool_n;
    kv_request_t r;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Empty table, extreme keys and values, updates and ignored data on a get.
    queue_request(OP_GET, 32'h0000_0000, 32'h0000_0000);
    queue_request(OP_SET, 32'h8000_0000, 32'h7fff_ffff);
    queue_request(OP_SET, 32'h7fff_ffff, 32'h8000_0000);
    queue_request(OP_SET, 32'h0000_0000, 32'h0000_0000);
    queue_request(OP_SET, 32'hffff_ffff, 32'hffff_ffff);
    queue_request(OP_GET, 32'h8000_0000, 32'h0000_0000);
    queue_request(OP_GET, 32'h7fff_ffff, 32'hffff_ffff);
    queue_request(OP_GET, 32'h0000_0000, 32'h0000_0000);
    queue_request(OP_GET, 32'hffff_ffff, 32'h0000_0000);
    queue_request(OP_SET, 32'h8000_0000, 32'h1234_5678);
    queue_request(OP_GET, 32'h8000_0000, 32'hdead_beef);
    queue_request(OP_GET, 32'h0000_0001, 32'h0000_0000);
    wait_idle();

    // A capacity of zero behaves as one and keeps only the newest entry.
    write_capacity(CAP_W'(0));
    queue_request(OP_GET, 32'h8000_0000, 32'h0000_0000);
    queue_request(OP_GET, 32'hffff_ffff, 32'h0000_0000);
    queue_request(OP_SET, 32'h0000_0005, 32'h0000_0037);
    queue_request(OP_GET, 32'h8000_0000, 32'h0000_0000);
    queue_request(OP_GET, 32'h0000_0005, 32'h0000_0000);
    queue_request(OP_SET, 32'h0000_0005, 32'h0000_0042);
    queue_request(OP_GET, 32'h0000_0005, 32'h0000_0000);
    wait_idle();

    for (int p = 0; p < 12; p++) begin
      write_capacity(CAP_W'(cap_plan[p]));
      steady = (p == CALM_PHASE);
      // A key set a little larger than the table gives a mix of hits,
      // updates and evictions.
      pool_n = usable_entries() + 3;
      for (int i = 0; i < pool_n; i++) begin
        case ($urandom_range(0, 9))
          0: key_pool[i] = 32'h8000_0000;
          1: key_pool[i] = 32'h7fff_ffff;
          2: key_pool[i] = '0;
          3: key_pool[i] = '1;
          default: key_pool[i] = $urandom();
        endcase
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        r.op = $urandom_range(0, 1) ? OP_SET : OP_GET;
        r.key = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, pool_n - 1)]
                                              : $urandom();
        r.data = $urandom();
        queue_request(r.op, r.key, r.data);
      end
      wait_idle();
    end
    steady = 1'b0;

    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
